FILE: rtl/core/lts_pkg.sv
// Shared types and constants for the tail table binary search unit.
package lts_pkg;

    localparam int VALUE_W     = 32;
    localparam int LEN_W       = 11;
    localparam int MAX_LEN_DEF = 1024;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } in_word_t;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic             overflow;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAST_RD,
        ST_CMP,
        ST_SRCH,
        ST_WRITE
    } state_t;

endpackage

FILE: rtl/core/lts_tail_ram.sv
// Single-port-write, registered-read memory that holds the tail table.
module lts_tail_ram import lts_pkg::*;
#(
    parameter int DEPTH  = MAX_LEN_DEF,
    parameter int ADDR_W = 10,
    parameter int DATA_W = VALUE_W
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/lis_tail_table_binary_search_unit.sv
// Top level: longest strictly increasing subsequence length by patience sorting.
//
// Usage: send one signed value per word on the item channel (item_valid,
// item_stall, item); the last flag marks the final value of a sequence.
// Each accepted word yields exactly one result word (length so far and a
// sticky overflow flag) on the result channel (result_valid, result_stall).
// Tails live in a MAX_LEN-entry memory with a registered read. An item
// passes an accept state, a read of the largest tail, a compare state, up
// to ceil(log2(MAX_LEN)) search steps (10 for 1024) and a write state.
// An append or a sequence's first value skips the search. The binary
// search loop, one memory read per step, sets the rate. The result is
// valid in the cycle after the write cycle, when a new item can already
// be taken.
// The result register frees the item side: a new item is accepted while a
// result waits; if the receiver still stalls when the next one is ready,
// the block holds in its write cycle. Reset empties the table and clears
// the flag at once; the table itself is never swept. After a word with
// last set, the length and the flag clear for the next sequence.
module lis_tail_table_binary_search_unit import lts_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_word_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_word_t result
);

    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W  = $clog2(MAX_LEN + 1);

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      ovf_reg, ovf_next;
    logic signed [VALUE_W-1:0] key_reg, key_next;
    logic                      last_reg, last_next;
    logic [ADDR_W-1:0]         lo_reg, lo_next;
    logic [ADDR_W-1:0]         hi_reg, hi_next;
    logic [ADDR_W-1:0]         mid_reg, mid_next;
    logic                      wr_en_reg, wr_en_next;
    logic [ADDR_W-1:0]         wr_addr_reg, wr_addr_next;
    logic [CNT_W-1:0]          new_count_reg, new_count_next;
    logic                      new_ovf_reg, new_ovf_next;
    logic                      res_valid_reg, res_valid_next;
    out_word_t                 res_word_reg, res_word_next;

    logic [ADDR_W-1:0]         rd_addr;
    logic [VALUE_W-1:0]        rd_data;
    logic                      ram_we;
    logic [CNT_W-1:0]          count_m1;
    logic [ADDR_W-1:0]         last_idx;
    logic                      less;
    logic [ADDR_W-1:0]         lo_s, hi_s;
    logic [ADDR_W:0]           mid_sum;
    logic                      res_free;
    logic [CNT_W+LEN_W-1:0]    len_wide;

    lts_tail_ram #(
        .DEPTH  (MAX_LEN),
        .ADDR_W (ADDR_W),
        .DATA_W (VALUE_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr_reg),
        .wdata (key_reg),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign count_m1 = count_reg - CNT_W'(1);
    assign last_idx = count_m1[ADDR_W-1:0];
    assign less     = $signed(rd_data) < key_reg;
    assign res_free = !res_valid_reg || !result_stall;
    assign len_wide = {{LEN_W{1'b0}}, new_count_reg};
    assign ram_we   = (state_reg == ST_WRITE) && res_free && wr_en_reg;

    // Narrow the search window on the tail read in the previous cycle.
    assign lo_s    = less ? (mid_reg + ADDR_W'(1)) : lo_reg;
    assign hi_s    = less ? hi_reg : mid_reg;
    assign mid_sum = {1'b0, lo_s} + {1'b0, hi_s};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        key_next       = key_reg;
        last_next      = last_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        wr_en_next     = wr_en_reg;
        wr_addr_next   = wr_addr_reg;
        new_count_next = new_count_reg;
        new_ovf_next   = new_ovf_reg;
        res_valid_next = res_valid_reg && result_stall;
        res_word_next  = res_word_reg;
        rd_addr        = mid_reg;
        item_stall     = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    key_next  = item.value;
                    last_next = item.last;
                    if (count_reg == '0)
                    begin
                        wr_en_next     = 1'b1;
                        wr_addr_next   = '0;
                        new_count_next = CNT_W'(1);
                        new_ovf_next   = ovf_reg;
                        state_next     = ST_WRITE;
                    end
                    else
                    begin
                        state_next = ST_LAST_RD;
                    end
                end
            end
            ST_LAST_RD:
            begin
                rd_addr    = last_idx;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                new_count_next = count_reg;
                new_ovf_next   = ovf_reg;
                if (less)
                begin
                    // Read data is the largest tail: append or drop.
                    if (count_reg < CNT_W'(MAX_LEN))
                    begin
                        wr_en_next     = 1'b1;
                        wr_addr_next   = count_reg[ADDR_W-1:0];
                        new_count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        wr_en_next   = 1'b0;
                        new_ovf_next = 1'b1;
                    end
                    state_next = ST_WRITE;
                end
                else if (last_idx == '0)
                begin
                    wr_en_next   = 1'b1;
                    wr_addr_next = '0;
                    state_next   = ST_WRITE;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = last_idx;
                    mid_next   = last_idx >> 1;
                    rd_addr    = last_idx >> 1;
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH:
            begin
                lo_next  = lo_s;
                hi_next  = hi_s;
                mid_next = mid_sum[ADDR_W:1];
                rd_addr  = mid_sum[ADDR_W:1];
                if (lo_s == hi_s)
                begin
                    wr_en_next   = 1'b1;
                    wr_addr_next = lo_s;
                    state_next   = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                // Hold here until the result register can take the word.
                if (res_free)
                begin
                    res_valid_next         = 1'b1;
                    res_word_next.length   = len_wide[LEN_W-1:0];
                    res_word_next.overflow = new_ovf_reg;
                    count_next             = last_reg ? '0 : new_count_reg;
                    ovf_next               = last_reg ? 1'b0 : new_ovf_reg;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            wr_en_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            wr_en_reg     <= wr_en_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        last_reg      <= last_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        wr_addr_reg   <= wr_addr_next;
        new_count_reg <= new_count_next;
        new_ovf_reg   <= new_ovf_next;
        res_word_reg  <= res_word_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_word_reg;

endmodule

FILE: rtl/core/lts_checker.sv
// Port-level checker for the tail table binary search unit, bound to the top level.
module lts_checker import lts_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      item_valid,
    input logic      item_stall,
    input in_word_t  item,
    input logic      result_valid,
    input logic      result_stall,
    input out_word_t result
);

    // Block works on one word at a time: busy right after an accept.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("item accepted while previous word in flight");

    // No result can be produced in the cycle right after an accept.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> !$rose(result_valid))
        else $error("result appeared too early after accept");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid)
        else $error("result word dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> $stable(result))
        else $error("result word changed while stalled");

endmodule

bind lis_tail_table_binary_search_unit lts_checker u_lts_checker (.*);
